// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the stencil step RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/gds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and the per-cell diffusion function of the stencil step core.
package gds_pkg;

	localparam int VALUE_W     = 32;
	localparam int COL_W       = 6;
	localparam int ROW_W       = 12;
	localparam int RATE_W      = 15;
	localparam int COLS_CFG_W  = 7;
	localparam int ROWS_CFG_W  = 13;
	localparam int CFG_DATA_W  = 15;
	localparam int CFG_INDEX_W = 2;
	localparam int RESULTS     = 3;
	localparam int NEIGHBORS   = 4;
	localparam int MIN_DIM     = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DIFFUSION_RATE = 2'd2;

	localparam int GRID_COLUMNS_RST = 10;
	localparam int GRID_ROWS_RST    = 8;
	localparam logic [RATE_W-1:0] RATE_RST = 15'd655;
	localparam logic [RATE_W-1:0] RATE_CAP = 15'd16384;

	localparam int SUM_W  = VALUE_W + 4;
	localparam int PROD_W = SUM_W + RATE_W + 1;
	localparam int FRAC_W = 16;

	typedef logic [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic above;
		logic up2_ok;
		logic left_ok;
		logic left2_ok;
		logic right_ok;
		logic last_row;
		logic final_col;
	} ctl_t;

	typedef struct packed {
		value_t x;
		value_t mid;
		value_t left;
		value_t right;
		value_t up2;
		value_t x1;
		value_t x2;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		ctl_t ctl;
	} ops_t;

	function automatic value_t diffuse(
		input value_t own,
		input logic [NEIGHBORS-1:0][VALUE_W-1:0] nb,
		input logic [NEIGHBORS-1:0] en,
		input logic [RATE_W-1:0] rate
	);
		logic signed [SUM_W-1:0] sum;
		logic signed [PROD_W-1:0] prod;
		logic signed [PROD_W-FRAC_W-1:0] delta;
		logic signed [VALUE_W+4:0] v;
		value_t res;
		sum = '0;
		for (int i = 0; i < NEIGHBORS; i++) begin
			if (en[i]) begin
				sum = sum + $signed({4'b0, nb[i]}) - $signed({4'b0, own});
			end
		end
		prod = sum * $signed({1'b0, rate});
		delta = $signed(prod[PROD_W-1:FRAC_W]);
		v = $signed({5'b0, own}) + delta;
		if (v < 0) begin
			res = '0;
		end else if (v[VALUE_W+4:VALUE_W] != '0) begin
			res = '1;
		end else begin
			res = v[VALUE_W-1:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gds_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// Configuration register file with range clamping and grid restart.
module gds_cfg_regs #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS = 4096,
	parameter int CW = $clog2(MAX_COLUMNS),
	parameter int RW = $clog2(MAX_ROWS)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [gds_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [gds_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic restart,
	output logic [CW-1:0] last_col,
	output logic [RW-1:0] last_row,
	output logic [gds_pkg::RATE_W-1:0] rate
);

	localparam int RST_COLS = (gds_pkg::GRID_COLUMNS_RST > MAX_COLUMNS) ?
		MAX_COLUMNS : gds_pkg::GRID_COLUMNS_RST;
	localparam int RST_ROWS = (gds_pkg::GRID_ROWS_RST > MAX_ROWS) ?
		MAX_ROWS : gds_pkg::GRID_ROWS_RST;

	logic wr;
	logic known;
	logic [31:0] cols_in, cols_eff, rows_in, rows_eff;
	logic [gds_pkg::RATE_W-1:0] rate_in;
	logic [CW-1:0] last_col_q;
	logic [RW-1:0] last_row_q;
	logic [gds_pkg::RATE_W-1:0] rate_q;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;
	assign restart = wr && known;
	assign last_col = last_col_q;
	assign last_row = last_row_q;
	assign rate = rate_q;

	always_comb begin
		unique case (cfg_index)
			gds_pkg::REG_GRID_COLUMNS,
			gds_pkg::REG_GRID_ROWS,
			gds_pkg::REG_DIFFUSION_RATE: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	always_comb begin
		cols_in = 32'(cfg_data[gds_pkg::COLS_CFG_W-1:0]);
		rows_in = 32'(cfg_data[gds_pkg::ROWS_CFG_W-1:0]);
		rate_in = cfg_data[gds_pkg::RATE_W-1:0];
		if (cols_in < 32'(gds_pkg::MIN_DIM)) begin
			cols_eff = 32'(gds_pkg::MIN_DIM);
		end else if (cols_in > 32'(MAX_COLUMNS)) begin
			cols_eff = 32'(MAX_COLUMNS);
		end else begin
			cols_eff = cols_in;
		end
		if (rows_in < 32'(gds_pkg::MIN_DIM)) begin
			rows_eff = 32'(gds_pkg::MIN_DIM);
		end else if (rows_in > 32'(MAX_ROWS)) begin
			rows_eff = 32'(MAX_ROWS);
		end else begin
			rows_eff = rows_in;
		end
		if (rate_in > gds_pkg::RATE_CAP) begin
			rate_in = gds_pkg::RATE_CAP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= CW'(RST_COLS - 1);
			last_row_q <= RW'(RST_ROWS - 1);
			rate_q     <= gds_pkg::RATE_RST;
		end else if (wr) begin
			unique case (cfg_index)
				gds_pkg::REG_GRID_COLUMNS: last_col_q <= CW'(cols_eff - 32'd1);
				gds_pkg::REG_GRID_ROWS: last_row_q <= RW'(rows_eff - 32'd1);
				gds_pkg::REG_DIFFUSION_RATE: rate_q <= rate_in;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/gds_line_window.sv
`timescale 1ns / 1ps
`default_nettype none
// Raster counters, two parity row banks and the neighbor window around the incoming cell.
module gds_line_window #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS = 4096,
	parameter int CW = $clog2(MAX_COLUMNS),
	parameter int RW = $clog2(MAX_ROWS)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic accept,
	input  wire logic restart,
	input  wire logic [gds_pkg::VALUE_W-1:0] cell_value,
	input  wire logic [CW-1:0] last_col,
	input  wire logic [RW-1:0] last_row,
	output gds_pkg::ops_t ops
);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic rsel_q;
	gds_pkg::value_t left_q, mid_q, rreg_q, first_q, second_q, x1_q, x2_q;
	gds_pkg::value_t rd0_q, rd1_q;
	gds_pkg::value_t bank0 [MAX_COLUMNS];
	gds_pkg::value_t bank1 [MAX_COLUMNS];
	gds_pkg::value_t right_v, up2_v;
	logic wrap_col, wrap_row;
	logic [CW-1:0] addr_same, addr_other, addr0, addr1;

	assign wrap_col = col_q == last_col;
	assign wrap_row = row_q == last_row;

	// bank of the current row parity holds row r-2, the other bank row r-1
	assign right_v = rsel_q ? rreg_q : (row_q[0] ? rd0_q : rd1_q);
	assign up2_v = row_q[0] ? rd1_q : rd0_q;

	assign addr_same = col_q + CW'(1);
	assign addr_other = wrap_col ? '0 : col_q + CW'(2);
	assign addr0 = row_q[0] ? addr_other : addr_same;
	assign addr1 = row_q[0] ? addr_same : addr_other;

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!row_q[0]) begin
				bank0[col_q] <= cell_value;
			end
			rd0_q <= bank0[addr0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (row_q[0]) begin
				bank1[col_q] <= cell_value;
			end
			rd1_q <= bank1[addr1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			rsel_q <= 1'b0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (wrap_col) begin
				col_q  <= '0;
				row_q  <= wrap_row ? '0 : row_q + RW'(1);
				rsel_q <= 1'b1;
			end else begin
				col_q  <= col_q + CW'(1);
				rsel_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x1_q <= cell_value;
			x2_q <= x1_q;
			if (col_q == '0) begin
				first_q <= cell_value;
			end
			if (col_q == CW'(1)) begin
				second_q <= cell_value;
			end
			if (wrap_col) begin
				mid_q  <= first_q;
				rreg_q <= (col_q == CW'(1)) ? cell_value : second_q;
			end else begin
				left_q <= mid_q;
				mid_q  <= right_v;
			end
		end
	end

	always_comb begin
		ops.x   = cell_value;
		ops.mid = mid_q;
		ops.left = left_q;
		ops.right = right_v;
		ops.up2 = up2_v;
		ops.x1  = x1_q;
		ops.x2  = x2_q;
		ops.col = gds_pkg::COL_W'(col_q);
		ops.row = gds_pkg::ROW_W'(row_q);
		ops.ctl.above     = row_q != '0;
		ops.ctl.up2_ok    = row_q > RW'(1);
		ops.ctl.left_ok   = col_q != '0;
		ops.ctl.left2_ok  = col_q > CW'(1);
		ops.ctl.right_ok  = !wrap_col;
		ops.ctl.last_row  = wrap_row;
		ops.ctl.final_col = wrap_col;
	end

endmodule
`default_nettype wire

// File: hw/rtl/gds_stencil_calc.sv
`timescale 1ns / 1ps
`default_nettype none
// Input register, three stencil updates, result buffer draining one item per unstalled cycle.
module gds_stencil_calc (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire gds_pkg::ops_t ops,
	input  wire logic [gds_pkg::RATE_W-1:0] rate,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [gds_pkg::VALUE_W-1:0] new_value,
	output logic [gds_pkg::COL_W-1:0] cell_column,
	output logic [gds_pkg::ROW_W-1:0] cell_row,
	output logic last_of_run
);

	localparam int N = gds_pkg::RESULTS;

	logic valid_s1;
	gds_pkg::ops_t ops_s1;
	logic [N-1:0] mask_s2;
	logic [N-1:0][gds_pkg::VALUE_W-1:0] val_s2;
	logic [N-1:0][gds_pkg::COL_W-1:0] col_s2;
	logic [N-1:0][gds_pkg::ROW_W-1:0] row_s2;

	logic [N-1:0] mask_c;
	logic [N-1:0][gds_pkg::VALUE_W-1:0] val_c;
	logic [N-1:0][gds_pkg::COL_W-1:0] col_c;
	logic [N-1:0][gds_pkg::ROW_W-1:0] row_c;

	logic [N-1:0] pick;
	logic [$clog2(N)-1:0] sel;
	logic last_one, adv, out_take, accept;

	assign out_valid = |mask_s2;
	assign out_take = out_valid && !out_stall;
	assign last_one = (mask_s2 & (mask_s2 - N'(1))) == '0;
	assign adv = !out_valid || (out_take && last_one);
	assign in_stall = valid_s1 && !adv;
	assign accept = in_valid && !in_stall;

	always_comb begin
		if (mask_s2[0]) begin
			sel = 2'd0;
		end else if (mask_s2[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
		pick = N'(1) << sel;
	end

	assign new_value = val_s2[sel];
	assign cell_column = col_s2[sel];
	assign cell_row = row_s2[sel];
	assign last_of_run = last_one;

	// cell above, left neighbor on the last row, final cell of the grid
	always_comb begin
		mask_c[0] = ops_s1.ctl.above;
		mask_c[1] = ops_s1.ctl.last_row && ops_s1.ctl.left_ok;
		mask_c[2] = ops_s1.ctl.last_row && ops_s1.ctl.final_col;
		val_c[0] = gds_pkg::diffuse(ops_s1.mid,
			{ops_s1.up2, ops_s1.left, ops_s1.right, ops_s1.x},
			{ops_s1.ctl.up2_ok, ops_s1.ctl.left_ok, ops_s1.ctl.right_ok, 1'b1}, rate);
		val_c[1] = gds_pkg::diffuse(ops_s1.x1,
			{ops_s1.left, ops_s1.x2, ops_s1.x, ops_s1.x},
			{1'b1, ops_s1.ctl.left2_ok, 1'b1, 1'b0}, rate);
		val_c[2] = gds_pkg::diffuse(ops_s1.x,
			{ops_s1.mid, ops_s1.x1, ops_s1.x, ops_s1.x},
			{1'b1, 1'b1, 1'b0, 1'b0}, rate);
		col_c[0] = ops_s1.col;
		row_c[0] = ops_s1.row - gds_pkg::ROW_W'(1);
		col_c[1] = ops_s1.col - gds_pkg::COL_W'(1);
		row_c[1] = ops_s1.row;
		col_c[2] = ops_s1.col;
		row_c[2] = ops_s1.row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mask_s2  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				mask_s2 <= valid_s1 ? mask_c : '0;
			end else if (out_take) begin
				mask_s2 <= mask_s2 & ~pick;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ops_s1 <= ops;
		end
		if (adv && valid_s1) begin
			val_s2 <= val_c;
			col_s2 <= col_c;
			row_s2 <= row_c;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/grid_diffusion_stencil_step_core.sv
// An accepted item is held in the input register and its results in the result buffer.
// Throughput: one item per cycle outside the last row while out_stall is low; a last-row item
// past column 0 yields two results (three for the final cell) and stalls the input until the
// last is taken. The result buffer drains one result per cycle while out_stall is low; the
// row banks take one write and one read each. Reset: counters return to cell (0,0), and other
// reset flops to their reset values; the row banks are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module grid_diffusion_stencil_step_core #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS = 4096
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [gds_pkg::VALUE_W-1:0] cell_value,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [gds_pkg::VALUE_W-1:0] new_value,
	output logic [gds_pkg::COL_W-1:0] cell_column,
	output logic [gds_pkg::ROW_W-1:0] cell_row,
	output logic last_of_run,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [gds_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [gds_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);

	logic restart;
	logic accept;
	logic [CW-1:0] last_col;
	logic [RW-1:0] last_row;
	logic [gds_pkg::RATE_W-1:0] rate;
	gds_pkg::ops_t ops;

	assign accept = in_valid && !in_stall;

	gds_cfg_regs #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.restart(restart),
		.last_col(last_col),
		.last_row(last_row),
		.rate(rate)
	);

	gds_line_window #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.restart(restart),
		.cell_value(cell_value),
		.last_col(last_col),
		.last_row(last_row),
		.ops(ops)
	);

	gds_stencil_calc u_calc (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ops(ops),
		.rate(rate),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.new_value(new_value),
		.cell_column(cell_column),
		.cell_row(cell_row),
		.last_of_run(last_of_run)
	);

	`ASSERT_IMPLIES(a_stall_needs_output, in_stall, out_valid, "input stalled with empty output")
	`ASSERT_IMPLIES(a_last_row_has_above, ops.ctl.last_row, ops.ctl.above, "last row is row 0")
	`ASSERT_NEXT(a_restart_origin, restart, (ops.col == '0) && (ops.row == '0), "restart missed")
	`ASSERT_NEXT(a_row_wrap, accept && ops.ctl.final_col && !restart, ops.col == '0, "no wrap")

endmodule
`default_nettype wire
